// File: src/rdsg_pkg.sv
// ----------------------------------------------------------------------------
// rdsg_pkg: shared types and constants for the dab scatter generator
// Register indexes, LCG constants, CORDIC table and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none
package rdsg_pkg;
  localparam int MaxDabs     = 64;
  localparam int CordicSteps = 24;
  localparam int StepW       = $clog2(CordicSteps + 1);

  localparam logic [31:0] LcgMul  = 32'd1664525;
  localparam logic [31:0] LcgInc  = 32'd1013904223;
  localparam logic [31:0] InvGain = 32'h9B74EDA8;
  localparam logic signed [21:0] OffMax = 22'sd1048575;

  localparam logic [1:0] RegScatterEn  = 2'd0;
  localparam logic [1:0] RegScatterAmt = 2'd1;
  localparam logic [1:0] RegJitterEn   = 2'd2;
  localparam logic [1:0] RegJitterDeg  = 2'd3;

  localparam logic OpBegin    = 1'b0;
  localparam logic OpGenerate = 1'b1;

  // datapath command
  localparam logic [3:0] CmdNone    = 4'd0;
  localparam logic [3:0] CmdLoad    = 4'd1;
  localparam logic [3:0] CmdDraw1   = 4'd2;  // draw u1, start sqrt
  localparam logic [3:0] CmdSqrt    = 4'd3;  // one sqrt step
  localparam logic [3:0] CmdRad1    = 4'd4;  // radius*amount
  localparam logic [3:0] CmdRad2    = 4'd5;  // *s
  localparam logic [3:0] CmdDraw2   = 4'd6;  // draw u2, x0 = r*InvGain
  localparam logic [3:0] CmdCordic  = 4'd7;  // one rotation step
  localparam logic [3:0] CmdFinish  = 4'd8;  // scale and saturate offsets
  localparam logic [3:0] CmdDraw3   = 4'd9;  // jitter draw
  localparam logic [3:0] CmdJitMul  = 4'd10;
  localparam logic [3:0] CmdClear   = 4'd11; // zero result fields

  typedef struct packed {
    logic [3:0] op;
    logic       last;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic cordic_done;
    logic out_busy;
  } dp_sts_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    begin
      case (i)
        5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;
        5'd2: t = 32'h09FB385B;  5'd3: t = 32'h051111D4;
        5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
        5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;
        5'd8: t = 32'h0028BE53;  5'd9: t = 32'h00145F2F;
        5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
        5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
        5'd14: t = 32'h0000A2F9; 5'd15: t = 32'h0000517C;
        5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
        5'd18: t = 32'h00000A2F; 5'd19: t = 32'h00000517;
        5'd20: t = 32'h0000028B; 5'd21: t = 32'h00000145;
        5'd22: t = 32'h000000A2; 5'd23: t = 32'h00000051;
        5'd24: t = 32'h00000028; 5'd25: t = 32'h00000014;
        5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
        5'd28: t = 32'h00000002; 5'd29: t = 32'h00000001;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction
endpackage
`default_nettype wire

// File: src/random_dab_scatter_generator.sv
// ----------------------------------------------------------------------------
// random_dab_scatter_generator: random dab offsets and rotations
// LCG-driven disk scatter (sqrt + CORDIC) and rotation jitter per dab.
// ----------------------------------------------------------------------------
// Input transactions: tdata {seed, count, radius} from bit 0 up, tuser =
// operation. Operation 0 loads the generator seed (no result); 1 emits count
// dabs (capped at 64), tlast on the final dab. Count zero emits nothing.
// Each dab passes clear, then for scatter a draw, 24 sqrt steps and an exit
// state, two multiplies, a draw, 24 CORDIC steps and an exit state and
// finish, then for jitter a draw and a multiply, and last emit. The sqrt and
// CORDIC step loops share one datapath that takes one command at a time.
// in_tready is high only while the sequencer is idle; one input item is
// worked at a time. The result register holds a dab while the receiver
// stalls; the sequencer waits at the emit step until it is free.
// Reset (rst_n low, synchronous) clears the seed to 0 and the registers to
// their defaults: scatter off, amount 1.0, jitter off, 0 degrees.
// Configuration writes take effect at once and must occur while idle.
// ----------------------------------------------------------------------------
`default_nettype none
module random_dab_scatter_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // seed[31:0], count[38:32], radius[56:39]
  input  wire logic        in_tuser,   // operation
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // offset_x[20:0], offset_y[41:21], angle[58:42]
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic scat_en_r, jit_en_r;
  logic [15:0] amt_r, deg_r;
  logic [17:0] radius_r;
  logic in_fire, idle;
  rdsg_pkg::dp_cmd_t cmd;
  rdsg_pkg::dp_sts_t sts;

  assign in_tready = idle;
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scat_en_r <= 1'b0;
      jit_en_r <= 1'b0;
      amt_r <= 16'd16384;
      deg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rdsg_pkg::RegScatterEn:  scat_en_r <= cfg_data[0];
        rdsg_pkg::RegScatterAmt: amt_r <= cfg_data;
        rdsg_pkg::RegJitterEn:   jit_en_r <= cfg_data[0];
        rdsg_pkg::RegJitterDeg:  deg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) radius_r <= in_tdata[56:39];
  end

  rdsg_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .op(in_tuser), .count(in_tdata[38:32]),
    .scatter_en(scat_en_r), .jitter_en(jit_en_r), .sts, .cmd, .idle
  );

  rdsg_datapath u_dp (
    .clk, .rst_n, .cmd, .sts, .seed(in_tdata[31:0]), .radius(radius_r),
    .scatter_amount(amt_r), .jitter_degrees(deg_r),
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

  logic unused;
  assign unused = ^in_tdata[63:57];

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped under stall");
  a_data_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed under stall");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser |=> !in_tready || !$past(in_tdata[38:32] != 7'd0))
    else $error("accepted while generating");
endmodule
`default_nettype wire

// File: src/rdsg_datapath.sv
// ----------------------------------------------------------------------------
// rdsg_datapath: generator, square root, CORDIC and jitter arithmetic
// Executes one controller command per cycle; holds the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module rdsg_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rdsg_pkg::dp_cmd_t  cmd,
  output rdsg_pkg::dp_sts_t       sts,
  input  wire logic [31:0]        seed,
  input  wire logic [17:0]        radius,
  input  wire logic [15:0]        scatter_amount,
  input  wire logic [15:0]        jitter_degrees,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [63:0]             out_tdata,
  output logic                    out_tlast
);
  logic [31:0] rng_r, rng_nxt;
  // sqrt: 48-bit radicand, 24-bit root, one result bit per step
  logic [47:0] rem_r;
  logic [23:0] root_r;
  logic [4:0]  sq_cnt_r;
  logic [33:0] prod_r;          // radius*amount
  logic [57:0] rad_r;           // radius*amount*s
  logic [19:0] r_q8;
  logic signed [53:0] cx_r, cy_r;
  logic signed [33:0] cz_r;
  logic [4:0]  cs_r;
  logic        flip_r;
  logic signed [20:0] ox_r, oy_r, ang_r;
  logic signed [41:0] jt_r;
  logic        ov_r, ol_r;
  logic [63:0] od_r;            // result held until the receiver takes it
  logic [31:0] ph;
  logic [31:0] ph_f;
  logic signed [53:0] dx, dy;
  logic signed [53:0] xs, ys;
  logic signed [41:0] xq, yq;
  logic [49:0] trial;
  logic [52:0] x0;

  assign rng_nxt = rng_r * rdsg_pkg::LcgMul + rdsg_pkg::LcgInc;
  assign r_q8 = rad_r[57:38];
  assign ph = {rng_nxt[31:8], 8'd0};
  assign ph_f = (ph[31] ^ ph[30]) ? ph + 32'h80000000 : ph;
  assign dx = cy_r >>> cs_r;
  assign dy = cx_r >>> cs_r;
  assign trial = {rem_r[47:46], 48'd0} | 50'd0;
  assign x0 = ({33'd0, r_q8} * {21'd0, rdsg_pkg::InvGain}) >> 20;
  assign xs = cx_r >>> 12;
  assign ys = cy_r >>> 12;
  assign xq = flip_r ? -42'(xs) : 42'(xs);
  assign yq = flip_r ? -42'(ys) : 42'(ys);

  function automatic logic signed [20:0] sat(input logic signed [41:0] v);
    begin
      if (v > 42'(rdsg_pkg::OffMax)) return 21'(rdsg_pkg::OffMax);
      if (v < -42'(rdsg_pkg::OffMax)) return -21'(rdsg_pkg::OffMax);
      return v[20:0];
    end
  endfunction

  // restoring sqrt on a shifted remainder: bring down two bits per step
  logic [49:0] acc_r;
  logic [49:0] acc_sh;
  logic [25:0] tst;
  assign acc_sh = {acc_r[47:0], rem_r[47:46]};
  assign tst = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rng_r <= '0;
      ov_r <= 1'b0;
    end else begin
      case (cmd.op)
        rdsg_pkg::CmdLoad: rng_r <= seed;
        rdsg_pkg::CmdDraw1: begin
          rng_r <= rng_nxt;
          rem_r <= {rng_nxt[31:8], 24'd0};
          acc_r <= '0;
          root_r <= '0;
          sq_cnt_r <= '0;
        end
        rdsg_pkg::CmdSqrt: begin
          rem_r <= {rem_r[45:0], 2'b00};
          sq_cnt_r <= sq_cnt_r + 5'd1;
          if (acc_sh >= {24'd0, tst}) begin
            acc_r <= acc_sh - {24'd0, tst};
            root_r <= {root_r[22:0], 1'b1};
          end else begin
            acc_r <= acc_sh;
            root_r <= {root_r[22:0], 1'b0};
          end
        end
        rdsg_pkg::CmdRad1: prod_r <= radius * scatter_amount;
        rdsg_pkg::CmdRad2: rad_r <= prod_r * root_r;
        rdsg_pkg::CmdDraw2: begin
          rng_r <= rng_nxt;
          flip_r <= ph[31] ^ ph[30];
          cz_r <= 34'(signed'(ph_f));
          cx_r <= 54'(x0);
          cy_r <= '0;
          cs_r <= '0;
        end
        rdsg_pkg::CmdCordic: begin
          cs_r <= cs_r + 5'd1;
          if (!cz_r[33]) begin
            cx_r <= cx_r - dx;
            cy_r <= cy_r + dy;
            cz_r <= cz_r - 34'(rdsg_pkg::atan_turn(cs_r));
          end else begin
            cx_r <= cx_r + dx;
            cy_r <= cy_r - dy;
            cz_r <= cz_r + 34'(rdsg_pkg::atan_turn(cs_r));
          end
        end
        rdsg_pkg::CmdFinish: begin
          ox_r <= sat(xq);
          oy_r <= sat(yq);
        end
        rdsg_pkg::CmdClear: begin
          ox_r <= '0;
          oy_r <= '0;
          ang_r <= '0;
        end
        rdsg_pkg::CmdDraw3: begin
          rng_r <= rng_nxt;
          jt_r <= 42'(signed'({1'b0, rng_nxt[31:8], 1'b0}) - 27'sd16777216)
                  * signed'({1'b0, jitter_degrees});
        end
        rdsg_pkg::CmdJitMul: ang_r <= 21'(jt_r >>> 24);
        default: ;
      endcase
      if (cmd.emit) begin
        ov_r <= 1'b1;
        ol_r <= cmd.last;
        od_r <= {5'd0, ang_r[16:0], oy_r, ox_r};
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign sts.sqrt_done   = (sq_cnt_r == 5'd24);
  assign sts.cordic_done = ({27'd0, cs_r} == rdsg_pkg::CordicSteps);
  assign sts.out_busy    = ov_r && !out_tready;
  assign out_tvalid = ov_r;
  assign out_tlast  = ol_r;
  assign out_tdata  = od_r;
  logic unused;
  assign unused = ^{trial, ang_r[20:17], x0[52:51]};
endmodule
`default_nettype wire

// File: src/rdsg_ctrl.sv
// ----------------------------------------------------------------------------
// rdsg_ctrl: sequencer for the dab generator
// Walks sqrt, CORDIC and jitter steps per dab and counts dabs left.
// ----------------------------------------------------------------------------
`default_nettype none
module rdsg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_fire,
  input  wire logic              op,
  input  wire logic [6:0]        count,
  input  wire logic              scatter_en,
  input  wire logic              jitter_en,
  input  wire rdsg_pkg::dp_sts_t sts,
  output rdsg_pkg::dp_cmd_t      cmd,
  output logic                   idle
);
  localparam logic [3:0] SIdle = 4'd0, SClr = 4'd1, SD1 = 4'd2, SSq = 4'd3,
    SR1 = 4'd4, SR2 = 4'd5, SD2 = 4'd6, SCor = 4'd7, SFin = 4'd8,
    SD3 = 4'd9, SJm = 4'd10, SEmit = 4'd11;
  logic [3:0] st_r, st_nxt;
  logic [6:0] left_r, left_nxt;

  always_comb begin
    st_nxt = st_r;
    left_nxt = left_r;
    cmd = '{op: rdsg_pkg::CmdNone, last: 1'b0, emit: 1'b0};
    case (st_r)
      SIdle: if (in_fire) begin
        if (op == rdsg_pkg::OpBegin) cmd.op = rdsg_pkg::CmdLoad;
        else if (count != 7'd0) begin
          left_nxt = (count > 7'(rdsg_pkg::MaxDabs)) ? 7'(rdsg_pkg::MaxDabs) : count;
          st_nxt = SClr;
        end
      end
      SClr: begin
        cmd.op = rdsg_pkg::CmdClear;
        st_nxt = scatter_en ? SD1 : (jitter_en ? SD3 : SEmit);
      end
      SD1:  begin cmd.op = rdsg_pkg::CmdDraw1; st_nxt = SSq; end
      SSq: begin
        if (sts.sqrt_done) st_nxt = SR1;
        else cmd.op = rdsg_pkg::CmdSqrt;
      end
      SR1:  begin cmd.op = rdsg_pkg::CmdRad1; st_nxt = SR2; end
      SR2:  begin cmd.op = rdsg_pkg::CmdRad2; st_nxt = SD2; end
      SD2:  begin cmd.op = rdsg_pkg::CmdDraw2; st_nxt = SCor; end
      SCor: begin
        if (sts.cordic_done) st_nxt = SFin;
        else cmd.op = rdsg_pkg::CmdCordic;
      end
      SFin: begin
        cmd.op = rdsg_pkg::CmdFinish;
        st_nxt = jitter_en ? SD3 : SEmit;
      end
      SD3:  begin cmd.op = rdsg_pkg::CmdDraw3; st_nxt = SJm; end
      SJm:  begin cmd.op = rdsg_pkg::CmdJitMul; st_nxt = SEmit; end
      SEmit: if (!sts.out_busy) begin
        cmd.emit = 1'b1;
        cmd.last = (left_r == 7'd1);
        left_nxt = left_r - 7'd1;
        st_nxt = (left_r == 7'd1) ? SIdle : SClr;
      end
      default: st_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= SIdle;
      left_r <= '0;
    end else begin
      st_r <= st_nxt;
      left_r <= left_nxt;
    end
  end
  assign idle = (st_r == SIdle);
endmodule
`default_nettype wire

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: dab scatter generator check
// Drives seed loads and generate transactions with random idling on both
// sides, predicts every dab (LCG, sqrt, CORDIC, jitter) and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;

  class dab_scoreboard;
    bit          scat_en;
    bit   [15:0] scat_amt;
    bit          jit_en;
    bit   [15:0] jit_deg;
    bit   [31:0] lcg;
    bit   [20:0] exp_x[$];
    bit   [20:0] exp_y[$];
    bit   [16:0] exp_ang[$];
    bit          exp_last[$];
    int          mismatches;

    function void reset_state();
      scat_en = 0; scat_amt = 16384; jit_en = 0; jit_deg = 0; lcg = 0;
    endfunction

    function void set_reg(bit [1:0] idx, bit [15:0] val);
      case (idx)
        rdsg_pkg::RegScatterEn:  scat_en = val[0];
        rdsg_pkg::RegScatterAmt: scat_amt = val;
        rdsg_pkg::RegJitterEn:   jit_en = val[0];
        rdsg_pkg::RegJitterDeg:  jit_deg = val;
        default: ;
      endcase
    endfunction

    function bit [23:0] next_fraction();
      lcg = lcg * rdsg_pkg::LcgMul + rdsg_pkg::LcgInc;
      return lcg[31:8];
    endfunction

    function longint floor_shift(longint v, int sh);
      return v >>> sh;
    endfunction

    function longint clamp_off(longint v);
      if (v > 1048575) return 1048575;
      if (v < -1048575) return -1048575;
      return v;
    endfunction

    function void disk_offset(bit [17:0] radius, output longint ox, output longint oy);
      longint unsigned v, res, b, s, r;
      bit [31:0] ph, tbl;
      bit flip;
      longint z, x, y, dx, dy;
      v = longint'(next_fraction()) << 24;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else res = res >> 1;
        b = b >> 2;
      end
      s = res;
      r = (longint'(radius) * scat_amt * s) >> 38;
      ph = {next_fraction(), 8'h00};
      flip = (ph[31:30] == 2'd1) || (ph[31:30] == 2'd2);
      if (flip) ph = ph + 32'h80000000;
      z = longint'($signed(ph));
      x = longint'((r * rdsg_pkg::InvGain) >> 20);
      y = 0;
      for (int i = 0; i < rdsg_pkg::CordicSteps; i++) begin
        tbl = rdsg_pkg::atan_turn(i[4:0]);
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x = x - dx; y = y + dy; z = z - longint'(tbl);
        end else begin
          x = x + dx; y = y - dy; z = z + longint'(tbl);
        end
      end
      x = x >>> 12;
      y = y >>> 12;
      if (flip) begin
        x = -x; y = -y;
      end
      ox = clamp_off(x);
      oy = clamp_off(y);
    endfunction

    function int note_input(bit op, bit [31:0] seed, bit [6:0] cnt, bit [17:0] radius);
      int n;
      longint ox, oy, ang, t;
      if (op == rdsg_pkg::OpBegin) begin
        lcg = seed;
        return 0;
      end
      n = (cnt > rdsg_pkg::MaxDabs) ? rdsg_pkg::MaxDabs : cnt;
      for (int k = 0; k < n; k++) begin
        ox = 0; oy = 0; ang = 0;
        if (scat_en) disk_offset(radius, ox, oy);
        if (jit_en) begin
          t = longint'(next_fraction()) * 2 - (64'sd1 << 24);
          ang = (t * longint'(jit_deg)) >>> 24;
        end
        exp_x.push_back(ox[20:0]);
        exp_y.push_back(oy[20:0]);
        exp_ang.push_back(ang[16:0]);
        exp_last.push_back(k == n - 1);
      end
      return n;
    endfunction

    function void check_result(bit [63:0] data, bit last);
      bit [20:0] ex, ey;
      bit [16:0] ea;
      bit el;
      if (exp_x.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected dab: data=%h last=%0d", data, last);
        return;
      end
      ex = exp_x.pop_front(); ey = exp_y.pop_front();
      ea = exp_ang.pop_front(); el = exp_last.pop_front();
      if (data[20:0] !== ex || data[41:21] !== ey || data[58:42] !== ea || last !== el) begin
        mismatches++;
        if (mismatches <= 10)
          $display("dab mismatch: exp x=%h y=%h ang=%h last=%0d got x=%h y=%h ang=%h last=%0d",
                   ex, ey, ea, el, data[20:0], data[41:21], data[58:42], last);
      end
    endfunction

    function int pending();
      return exp_x.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // seed[31:0], count[38:32], radius[56:39]
  logic        in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // offset_x[20:0], offset_y[41:21], angle[58:42]
  logic        out_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  dab_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  longint cycles;

  random_dab_scatter_generator dut (.*);

  initial clk = 0;
  always #6 clk = ~clk;

  // receiver: ready changes on the falling edge, results sampled on the rising
  always @(negedge clk)
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    cycles++;
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    if (cycles > 3000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays up between back-to-back items unless an idle is drawn; drain() drops it
  task automatic send_item(bit op, bit [31:0] seed, bit [6:0] cnt, bit [17:0] radius);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, radius, cnt, seed};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    void'(sb.note_input(op, seed, cnt, radius));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [15:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic set_regs(bit se, bit [15:0] sa, bit je, bit [15:0] jd);
    drain();
    write_reg(rdsg_pkg::RegScatterEn, {15'd0, se});
    write_reg(rdsg_pkg::RegScatterAmt, sa);
    write_reg(rdsg_pkg::RegJitterEn, {15'd0, je});
    write_reg(rdsg_pkg::RegJitterDeg, jd);
    cfg_we <= 0;
  endtask

  // mostly short generates, a seed load in one item of five; random radius with full range
  task automatic random_item();
    bit [6:0] cnt;
    if ($urandom_range(99) < 20)
      send_item(rdsg_pkg::OpBegin, $urandom, 7'($urandom), 18'($urandom));
    else begin
      case ($urandom_range(9))
        0: cnt = 7'd0;
        1: cnt = 7'($urandom_range(127, 65));
        2: cnt = 7'($urandom_range(64, 20));
        default: cnt = 7'($urandom_range(6, 1));
      endcase
      send_item(rdsg_pkg::OpGenerate, $urandom, cnt, 18'($urandom));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    cycles = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = 0; in_tuser = 0; out_tready = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    send_idle_pct = 11; recv_idle_pct = 54;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // defaults: offsets and angle all zero
    send_item(rdsg_pkg::OpGenerate, 32'd0, 7'd3, 18'h3FFFF);
    set_regs(1'b1, 16'hFFFF, 1'b1, 16'd46080);
    send_item(rdsg_pkg::OpBegin, 32'hFFFFFFFF, 7'd0, 18'd0);
    send_item(rdsg_pkg::OpGenerate, 32'd0, 7'd2, 18'h3FFFF);
    send_item(rdsg_pkg::OpGenerate, 32'h0, 7'd0, 18'h3FFFF);
    send_item(rdsg_pkg::OpGenerate, 32'h0, 7'd127, 18'h3FFFF);
    send_item(rdsg_pkg::OpBegin, 32'h0, 7'h7F, 18'h3FFFF);
    send_item(rdsg_pkg::OpGenerate, 32'hFFFFFFFF, 7'd64, 18'd0);
    send_item(rdsg_pkg::OpGenerate, 32'd0, 7'd1, 18'd256);
    set_regs(1'b1, 16'd0, 1'b0, 16'hFFFF);
    send_item(rdsg_pkg::OpGenerate, 32'd0, 7'd2, 18'h3FFFF);
    set_regs(1'b0, 16'd16384, 1'b1, 16'd1);
    send_item(rdsg_pkg::OpGenerate, 32'd0, 7'd3, 18'h155);
    set_regs(1'b1, 16'd16384, 1'b0, 16'd0);
    send_item(rdsg_pkg::OpGenerate, 32'd0, 7'd4, 18'h2AAAA);

    // pause until every dab has come out
    drain();
    set_regs(1'b1, 16'd16384, 1'b1, 16'd11520);
    for (int i = 0; i < 150; i++) random_item();
    send_idle_pct = 54; recv_idle_pct = 11;
    set_regs(1'b1, 16'($urandom), 1'b1, 16'($urandom_range(46080)));
    for (int i = 0; i < 150; i++) random_item();
    send_idle_pct = 0; recv_idle_pct = 0;
    set_regs(1'($urandom), 16'($urandom), 1'($urandom), 16'($urandom));
    for (int i = 0; i < 150; i++) random_item();
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
